>>> hw/rtl/lru_page_replacement_macros.svh
// assertion helpers shared by the checker
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int CFG_W          = 5;
	localparam int PAGE_W         = 8;
	localparam int FRAME_IDX_W    = 4;
	localparam int CNT_W          = 32;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} lru_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} lru_stat_t;

endpackage

>>> hw/rtl/lru_ctrl.sv
`timescale 1ns / 1ps

module lru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lru_pkg::lru_stat_t stat,
	output lru_pkg::lru_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				// wait until the result register can take the item
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/lru_datapath.sv
`timescale 1ns / 1ps

module lru_datapath #(
	parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [lru_pkg::CFG_W-1:0]       frames_in_use,
	input  logic [lru_pkg::PAGE_W-1:0]      reference_page,
	input  lru_pkg::lru_cmd_t               cmd,
	output lru_pkg::lru_stat_t              stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [lru_pkg::FRAME_IDX_W-1:0] frame_index,
	output logic                            evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]      evicted_page,
	output logic [lru_pkg::CNT_W-1:0]       fault_total,
	output logic [lru_pkg::CNT_W-1:0]       hit_total
);

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int LIM_W = 7;
	localparam logic [IDX_W-1:0] RANK_CEIL = IDX_W'(MAX_FRAMES - 1);

	// configuration and active frame limit
	logic [lru_pkg::CFG_W-1:0] frames_q;
	logic [LIM_W-1:0]          cfg_ext;
	logic [LIM_W-1:0]          lim;
	logic [IDX_W-1:0]          last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lru_pkg::FRAMES_RESET;
		end else if (cfg_valid) begin
			frames_q <= frames_in_use;
		end
	end

	assign cfg_ext = LIM_W'(frames_q);

	always_comb begin
		if (cfg_ext == '0) begin
			lim = '0;
		end else if (cfg_ext >= LIM_W'(MAX_FRAMES)) begin
			lim = LIM_W'(MAX_FRAMES - 1);
		end else begin
			lim = cfg_ext - LIM_W'(1);
		end
	end

	assign last_idx = lim[IDX_W-1:0];

	// frame storage
	logic [lru_pkg::PAGE_W-1:0] page_mem [MAX_FRAMES];
	logic [MAX_FRAMES-1:0]      valid_q;
	logic [IDX_W-1:0]           rank_q [MAX_FRAMES];

	// scan state
	logic [lru_pkg::PAGE_W-1:0] page_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       found_q;
	logic                       free_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic [IDX_W-1:0]           hit_rank_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic [IDX_W-1:0]           best_rank_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [lru_pkg::PAGE_W-1:0] best_page_q;

	logic [lru_pkg::PAGE_W-1:0] rd_page;
	logic [IDX_W-1:0]           rd_rank;
	logic                       rd_valid;

	assign rd_page  = page_mem[idx_q];
	assign rd_rank  = rank_q[idx_q];
	assign rd_valid = valid_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (!found_q && rd_valid && rd_page == page_q) begin
				found_q <= 1'b1;
			end
			if (!free_q && !rd_valid) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q      <= reference_page;
			best_rank_q <= '0;
			best_idx_q  <= '0;
			// with all ranks equal the first frame is the victim
			best_page_q <= page_mem[0];
		end else if (cmd.step) begin
			if (!found_q && rd_valid && rd_page == page_q) begin
				hit_idx_q  <= idx_q;
				hit_rank_q <= rd_rank;
			end
			if (!free_q && !rd_valid) begin
				free_idx_q <= idx_q;
			end
			if (rd_rank > best_rank_q) begin
				best_rank_q <= rd_rank;
				best_idx_q  <= idx_q;
				best_page_q <= rd_page;
			end
		end
	end

	assign stat.scan_last = (idx_q == last_idx);
	assign stat.out_free  = !out_valid || out_ready;

	// commit decisions
	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] old_rank;
	logic             age_all;
	logic             evict;

	always_comb begin
		age_all = 1'b0;
		if (found_q) begin
			sel_idx  = hit_idx_q;
			old_rank = hit_rank_q;
		end else if (free_q) begin
			sel_idx  = free_idx_q;
			old_rank = '0;
			// a new page is younger than every resident
			age_all  = 1'b1;
		end else begin
			sel_idx  = best_idx_q;
			old_rank = best_rank_q;
		end
	end

	assign evict = !found_q && !free_q;

	for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_frame
		logic age_en;

		assign age_en = (IDX_W'(j) <= last_idx) && valid_q[j]
			&& (age_all || rank_q[j] < old_rank) && (rank_q[j] < RANK_CEIL);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[j] <= 1'b0;
				rank_q[j]  <= '0;
			end else if (cmd.commit) begin
				if (IDX_W'(j) == sel_idx) begin
					valid_q[j] <= 1'b1;
					rank_q[j]  <= '0;
				end else if (age_en) begin
					rank_q[j] <= rank_q[j] + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !found_q) begin
			page_mem[sel_idx] <= page_q;
		end
	end

	// saturating counters
	logic [lru_pkg::CNT_W-1:0] fault_cnt_q;
	logic [lru_pkg::CNT_W-1:0] hit_cnt_q;
	logic [lru_pkg::CNT_W-1:0] fault_nxt;
	logic [lru_pkg::CNT_W-1:0] hit_nxt;

	always_comb begin
		fault_nxt = fault_cnt_q;
		hit_nxt   = hit_cnt_q;
		if (found_q) begin
			if (hit_cnt_q != '1) begin
				hit_nxt = hit_cnt_q + lru_pkg::CNT_W'(1);
			end
		end else begin
			if (fault_cnt_q != '1) begin
				fault_nxt = fault_cnt_q + lru_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_cnt_q <= '0;
			hit_cnt_q   <= '0;
		end else if (cmd.commit) begin
			fault_cnt_q <= fault_nxt;
			hit_cnt_q   <= hit_nxt;
		end
	end

	// result register
	logic                             out_valid_q;
	logic                             hit_q;
	logic [lru_pkg::FRAME_IDX_W-1:0]  frame_idx_q;
	logic                             ev_valid_q;
	logic [lru_pkg::PAGE_W-1:0]       ev_page_q;
	logic [lru_pkg::CNT_W-1:0]        fault_tot_q;
	logic [lru_pkg::CNT_W-1:0]        hit_tot_q;
	logic [IDX_W+lru_pkg::FRAME_IDX_W-1:0] sel_ext;

	assign sel_ext = {{lru_pkg::FRAME_IDX_W{1'b0}}, sel_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q       <= found_q;
			frame_idx_q <= sel_ext[lru_pkg::FRAME_IDX_W-1:0];
			ev_valid_q  <= evict;
			ev_page_q   <= evict ? best_page_q : '0;
			fault_tot_q <= fault_nxt;
			hit_tot_q   <= hit_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_idx_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_tot_q;
	assign hit_total     = hit_tot_q;

endmodule

>>> hw/rtl/lru_page_replacement.sv
// a new item is accepted only once the previous one is committed; the frames are scanned
// one per cycle through a single read port, then the write state commits the update and
// loads the result register, and it waits while the previous result waits for out_ready
// reset (async, active low): valid bits, ranks, counters and result valid clear,
// frames_in_use returns to 4; frame pages keep whatever they hold
`timescale 1ns / 1ps

module lru_page_replacement #(
	parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lru_pkg::CFG_W-1:0]       frames_in_use,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lru_pkg::PAGE_W-1:0]      reference_page,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [lru_pkg::FRAME_IDX_W-1:0] frame_index,
	output logic                            evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]      evicted_page,
	output logic [lru_pkg::CNT_W-1:0]       fault_total,
	output logic [lru_pkg::CNT_W-1:0]       hit_total
);

	lru_pkg::lru_cmd_t  cmd;
	lru_pkg::lru_stat_t stat;

	assign cfg_ready = 1'b1;

	lru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lru_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.frames_in_use  (frames_in_use),
		.reference_page (reference_page),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.frame_index    (frame_index),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.fault_total    (fault_total),
		.hit_total      (hit_total)
	);

endmodule

>>> hw/rtl/lru_checker.sv
`timescale 1ns / 1ps
`include "lru_page_replacement_macros.svh"

module lru_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            hit,
	input logic [lru_pkg::FRAME_IDX_W-1:0] frame_index,
	input logic                            evicted_valid,
	input logic [lru_pkg::PAGE_W-1:0]      evicted_page,
	input logic [lru_pkg::CNT_W-1:0]       fault_total,
	input logic [lru_pkg::CNT_W-1:0]       hit_total
);

	`LRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(frame_index) && $stable(fault_total) && $stable(hit_total), "result item changed while stalled")

	`LRU_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted_valid, "eviction reported on a hit")

	`LRU_ASSERT_NOW(a_evict_page_zero, out_valid && !evicted_valid, evicted_page == '0, "evicted page not zero without eviction")

	`LRU_ASSERT_NOW(a_totals_count, out_valid, (hit && hit_total != '0) || (!hit && fault_total != '0), "running total missed the item")

	`LRU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "new item taken while one is in the scan")

endmodule

bind lru_page_replacement lru_checker u_lru_checker (.*);
